@@ hw/rtl/tcp_checksum_pseudo_header_unit_macros.svh @@
// Assertion macros used by the checker file of the checksum block.
`ifndef TCP_CHECKSUM_PSEUDO_HEADER_UNIT_MACROS_SVH
`define TCP_CHECKSUM_PSEUDO_HEADER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define TCPCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcpcs assertion failed");

// Next-cycle implication, disabled while rst is high.
`define TCPCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcpcs assertion failed");

`endif

@@ hw/rtl/tcpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// TCP checksum package
// Widths and constants of the streamed TCP checksum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcpcs_pkg;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned IP_W   = 32;
   // Sum of six 16-bit pseudo-header terms before folding
   localparam int unsigned PSUM_W = 19;
   // Pseudo-header sum plus one data word
   localparam int unsigned TSUM_W = 20;

   localparam logic [WORD_W-1:0] IP_PROTO_TCP = 16'h0006;
   localparam logic [WORD_W-1:0] ODD_MASK     = 16'hFF00;

endpackage

@@ hw/rtl/tcp_checksum_pseudo_header_unit.sv @@
// An accepted last word passes the input and then the result register
// before its checksum shows on rsp_*. Throughput: one word per cycle while
// req_stall is low; a new word may enter while a finished checksum waits on
// rsp_stall. The running ones'-complement sum loops through running_sum_ff.
// Reset (synchronous, active high) clears local_ip, the sum and both valids.
// ----------------------------------------------------------------------------
// TCP checksum with pseudo-header
// Sums a segment streamed as 16-bit words, including the IPv4 pseudo-header,
// and emits the complemented ones'-complement sum on the last word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_checksum_pseudo_header_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [tcpcs_pkg::IP_W-1:0]    csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tcpcs_pkg::WORD_W-1:0]  req_data_word,
   input  logic                          req_last_word,
   input  logic [tcpcs_pkg::LEN_W-1:0]   req_segment_length,
   input  logic [tcpcs_pkg::IP_W-1:0]    req_peer_ip,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tcpcs_pkg::WORD_W-1:0]  rsp_checksum
);

   // configuration
   logic [tcpcs_pkg::IP_W-1:0]    local_ip_ff, local_ip_in;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic [tcpcs_pkg::WORD_W-1:0]  in_word_ff, in_word_in;
   logic                          in_last_ff, in_last_in;
   logic                          in_len_odd_ff, in_len_odd_in;
   logic [tcpcs_pkg::PSUM_W-1:0]  in_psum_ff, in_psum_in;

   // accumulator state
   logic [tcpcs_pkg::WORD_W-1:0]  running_sum_ff, running_sum_in;
   logic                          expect_first_ff, expect_first_in;
   logic                          length_odd_ff, length_odd_in;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic [tcpcs_pkg::WORD_W-1:0]  out_sum_ff, out_sum_in;

   logic                          req_take;
   logic                          advance;
   logic                          odd_now;
   logic [tcpcs_pkg::WORD_W-1:0]  word_masked;
   logic [tcpcs_pkg::PSUM_W-1:0]  base;
   logic [tcpcs_pkg::TSUM_W-1:0]  total;
   logic [tcpcs_pkg::WORD_W:0]    fold1;
   logic [tcpcs_pkg::WORD_W-1:0]  fold2;

   // A non-last item never blocks; a last one waits for a free result slot
   assign advance   = in_valid_ff && (!in_last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      local_ip_in = local_ip_ff;
      if (csr_wr_en) begin
         local_ip_in = csr_wr_data;
      end
   end

   // Input stage: hold the item and pre-add its pseudo-header terms
   always_comb begin
      in_valid_in   = in_valid_ff;
      in_word_in    = in_word_ff;
      in_last_in    = in_last_ff;
      in_len_odd_in = in_len_odd_ff;
      in_psum_in    = in_psum_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in   = 1'b1;
         in_word_in    = req_data_word;
         in_last_in    = req_last_word;
         in_len_odd_in = req_segment_length[0];
         in_psum_in    = tcpcs_pkg::PSUM_W'(local_ip_ff[31:16])
                       + tcpcs_pkg::PSUM_W'(local_ip_ff[15:0])
                       + tcpcs_pkg::PSUM_W'(req_peer_ip[31:16])
                       + tcpcs_pkg::PSUM_W'(req_peer_ip[15:0])
                       + tcpcs_pkg::PSUM_W'(tcpcs_pkg::IP_PROTO_TCP)
                       + tcpcs_pkg::PSUM_W'(req_segment_length);
      end
   end

   // Sum stage: ones'-complement add with two end-around folds
   always_comb begin
      odd_now     = expect_first_ff ? in_len_odd_ff : length_odd_ff;
      word_masked = (in_last_ff && odd_now) ? (in_word_ff & tcpcs_pkg::ODD_MASK)
                                            : in_word_ff;
      base        = expect_first_ff ? in_psum_ff : tcpcs_pkg::PSUM_W'(running_sum_ff);
      total       = tcpcs_pkg::TSUM_W'(base) + tcpcs_pkg::TSUM_W'(word_masked);
      fold1       = (tcpcs_pkg::WORD_W+1)'(total[tcpcs_pkg::WORD_W-1:0])
                  + (tcpcs_pkg::WORD_W+1)'(total[tcpcs_pkg::TSUM_W-1:tcpcs_pkg::WORD_W]);
      fold2       = fold1[tcpcs_pkg::WORD_W-1:0]
                  + tcpcs_pkg::WORD_W'(fold1[tcpcs_pkg::WORD_W]);
   end

   always_comb begin
      running_sum_in  = running_sum_ff;
      expect_first_in = expect_first_ff;
      length_odd_in   = length_odd_ff;
      out_valid_in    = out_valid_ff;
      out_sum_in      = out_sum_ff;
      if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         if (expect_first_ff) begin
            length_odd_in = in_len_odd_ff;
         end
         if (in_last_ff) begin
            running_sum_in  = '0;
            expect_first_in = 1'b1;
            out_valid_in    = 1'b1;
            out_sum_in      = ~fold2;
         end else begin
            running_sum_in  = fold2;
            expect_first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff     <= '0;
         in_valid_ff     <= 1'b0;
         running_sum_ff  <= '0;
         expect_first_ff <= 1'b1;
         length_odd_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         local_ip_ff     <= local_ip_in;
         in_valid_ff     <= in_valid_in;
         running_sum_ff  <= running_sum_in;
         expect_first_ff <= expect_first_in;
         length_odd_ff   <= length_odd_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff    <= in_word_in;
      in_last_ff    <= in_last_in;
      in_len_odd_ff <= in_len_odd_in;
      in_psum_ff    <= in_psum_in;
      out_sum_ff    <= out_sum_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_checksum = out_sum_ff;

endmodule

@@ hw/rtl/tcpcs_checker.sv @@
// ----------------------------------------------------------------------------
// TCP checksum port checker
// Watches the ports of the checksum block for handshake and timing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_checksum_pseudo_header_unit_macros.svh"

module tcpcs_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_last_word,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [tcpcs_pkg::WORD_W-1:0]  rsp_checksum
);

   // A stalled checksum holds until taken
   `TCPCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_checksum))

   // With the result slot empty the input side never stalls
   `TCPCS_ASSERT_IMPL(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // A fresh checksum comes from a last item taken earlier on the request port
   `TCPCS_ASSERT_IMPL(a_rsp_from_last, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && req_last_word, 2))

endmodule

bind tcp_checksum_pseudo_header_unit tcpcs_checker u_tcpcs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_word (req_last_word),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_checksum  (rsp_checksum)
);
